// ----- hw/rtl/gmaf_pkg.sv -----
// Shared types, constants and register codes for the geared modulo axis follower.
package gmaf_pkg;

    // Default number of segment table entries.
    localparam int unsigned SegmentsDefault = 16;

    // Width of the magnitude that the wrap modulo works on.
    localparam int unsigned ModW = 47;

    // Register reset values.
    localparam logic [30:0] DeadbandReset = 31'd1311;

    // Register indexes on the configuration port (byte address / 4).
    typedef enum logic [1:0] {
        REG_RUN_ENABLE = 2'd0,
        REG_DEADBAND   = 2'd1,
        REG_PERIOD     = 2'd2
    } reg_idx_t;

    // Operation codes of an input transaction.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // One input transaction.
    typedef struct packed {
        logic               opcode;
        logic               paused;
        logic [31:0]        elapsed_time;
        logic signed [31:0] drive_velocity;
        logic [3:0]         load_index;
        logic               load_valid;
        logic               load_tracks;
        logic signed [31:0] load_ratio;
        logic [30:0]        load_period;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic [3:0]         out_segment;
        logic signed [31:0] velocity_command;
        logic               reset_request;
        logic signed [31:0] wrap_position;
        logic               last;
    } out_item_t;

    // One entry of the segment memory.
    typedef struct packed {
        logic signed [31:0] gear;
        logic [30:0]        wrap;
        logic signed [31:0] pos;
    } seg_entry_t;

endpackage

// ----- hw/rtl/geared_modulo_axis_follower.sv -----
// Top level: segment memory, tick sequencer, velocity and position datapath, modulo unit.
// A load is absorbed as soon as it is accepted and leaves the input open; an enabled, unpaused
// tick closes the input and gives one result per active entry, from entry 0 upward, waiting
// while the output register is full; wrapping entries run a restoring division first.
// Reset (aresetn, synchronous, active low) clears control state, configuration registers and flags.
module geared_modulo_axis_follower
    import gmaf_pkg::*;
#(
    parameter int unsigned SEGMENTS = SegmentsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int unsigned CW = $clog2(SEGMENTS + 1);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_SCAN      = 11'b000_0000_0010,
        ST_VEL_MUL   = 11'b000_0000_0100,
        ST_VEL_SAT   = 11'b000_0000_1000,
        ST_POS_MUL   = 11'b000_0001_0000,
        ST_POS_ADD   = 11'b000_0010_0000,
        ST_WRAP_PREP = 11'b000_0100_0000,
        ST_DIV       = 11'b000_1000_0000,
        ST_WRAP_FIX  = 11'b001_0000_0000,
        ST_EMIT      = 11'b010_0000_0000,
        ST_SPARE     = 11'b100_0000_0000
    } state_t;

    // Configuration registers.
    logic        run_enable_reg;
    logic [30:0] deadband_reg;
    logic [31:0] period_reg;

    // Segment flags and memory.
    logic [SEGMENTS-1:0] active_reg, active_next;
    logic [SEGMENTS-1:0] track_reg, track_next;
    seg_entry_t          seg_mem [SEGMENTS];
    seg_entry_t          rd_data_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    seg_entry_t          mem_wdata;
    logic                mem_re;

    // Sequencer and datapath registers.
    state_t                  state_reg, state_next;
    logic [31:0]             acc_reg, acc_next;
    logic [31:0]             dt_reg, dt_next;
    logic                    due_reg, due_next;
    logic signed [31:0]      drive_reg, drive_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic signed [64:0]      prod_reg, prod_next;
    logic signed [31:0]      vel_reg, vel_next;
    logic signed [45:0]      u_reg, u_next;
    logic [ModW-1:0]         quo_reg, quo_next;
    logic [30:0]             rem_reg, rem_next;
    logic [5:0]              cnt_reg, cnt_next;
    logic                    neg_reg, neg_next;
    logic signed [31:0]      newpos_reg, newpos_next;
    logic                    rst_reg, rst_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    // Combinational helpers.
    logic                    cfg_write;
    logic [32:0]             acc_sum;
    logic [31:0]             acc_sat;
    logic                    tick_due;
    logic [32:0]             drive_mag;
    logic [AW-1:0]           idx_addr;
    logic                    idx_done;
    logic                    more_active;
    logic [29:0]             half;
    logic signed [47:0]      wrap_arg;
    logic [31:0]             div_cand;
    logic [30:0]             rem_fixed;
    logic signed [32:0]      wrapped;
    logic signed [47:0]      vel_shift;
    logic signed [44:0]      step_shift;

    assign idx_addr = idx_reg[AW-1:0];
    assign idx_done = (idx_reg == CW'(SEGMENTS));
    assign half     = rd_data_reg.wrap[30:1];

    // APB port: writes complete in the access phase, reads return the register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_RUN_ENABLE: prdata = {31'd0, run_enable_reg};
            REG_DEADBAND:   prdata = {1'b0, deadband_reg};
            REG_PERIOD:     prdata = period_reg;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_enable_reg <= 1'b0;
            deadband_reg   <= DeadbandReset;
            period_reg     <= '0;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_RUN_ENABLE: run_enable_reg <= pwdata[0];
                REG_DEADBAND:   deadband_reg   <= pwdata[30:0];
                REG_PERIOD:     period_reg     <= pwdata;
                default:        ;
            endcase
        end
    end

    // Handshake outputs.
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Tick arithmetic on the incoming transaction.
    assign acc_sum   = {1'b0, acc_reg} + {1'b0, s_data.elapsed_time};
    assign acc_sat   = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
    assign tick_due  = (period_reg == 32'd0) || (acc_sat >= period_reg);
    assign drive_mag = s_data.drive_velocity[31] ?
                       (33'd0 - {s_data.drive_velocity[31], s_data.drive_velocity}) :
                       {1'b0, s_data.drive_velocity};

    // Is there an active entry above the current one, so that this result is the last?
    always_comb begin
        more_active = 1'b0;
        for (int j = 0; j < SEGMENTS; j++) begin
            if (active_reg[j] && (CW'(j) > idx_reg)) begin
                more_active = 1'b1;
            end
        end
    end

    // Floor shifts of the two products.
    assign vel_shift  = 48'($signed(prod_reg[63:0]) >>> 16);
    assign step_shift = 45'(prod_reg >>> 20);

    // Modulo step and final correction.
    assign wrap_arg  = 48'(u_reg) + 48'(signed'({1'b0, half}));
    assign div_cand  = {rem_reg, quo_reg[ModW-1]};
    assign rem_fixed = (neg_reg && (rem_reg != 31'd0)) ? (rd_data_reg.wrap - rem_reg) : rem_reg;
    assign wrapped   = signed'({2'b00, rem_fixed}) - signed'({3'b000, half});

    // Sequencer and datapath next-state logic.
    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        dt_next      = dt_reg;
        due_next     = due_reg;
        drive_next   = drive_reg;
        idx_next     = idx_reg;
        prod_next    = prod_reg;
        vel_next     = vel_reg;
        u_next       = u_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        newpos_next  = newpos_reg;
        rst_next     = rst_reg;
        active_next  = active_reg;
        track_next   = track_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = idx_addr;
        mem_wdata    = '{gear: rd_data_reg.gear, wrap: rd_data_reg.wrap, pos: newpos_reg};
        mem_re       = 1'b0;

        // The output register frees as soon as its transaction is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.opcode == OP_LOAD) begin
                        // A load writes the whole entry and clears its position.
                        if (int'(s_data.load_index) < SEGMENTS) begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(s_data.load_index);
                            mem_wdata = '{gear: s_data.load_ratio,
                                          wrap: s_data.load_period, pos: '0};
                            active_next[AW'(s_data.load_index)] = s_data.load_valid;
                            track_next[AW'(s_data.load_index)]  = s_data.load_tracks;
                        end
                    end else if (!s_data.paused && run_enable_reg) begin
                        acc_next   = tick_due ? 32'd0 : acc_sat;
                        dt_next    = tick_due ? acc_sat : 32'd0;
                        due_next   = tick_due;
                        drive_next = (drive_mag < {2'b00, deadband_reg}) ?
                                     32'sd0 : s_data.drive_velocity;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (idx_done) begin
                    state_next = ST_IDLE;
                end else if (active_reg[idx_addr]) begin
                    mem_re     = 1'b1;
                    state_next = ST_VEL_MUL;
                end else begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_VEL_MUL: begin
                prod_next  = 65'(64'(drive_reg) * 64'(rd_data_reg.gear));
                state_next = ST_VEL_SAT;
            end
            ST_VEL_SAT: begin
                if (vel_shift > 48'sh0000_7FFF_FFFF) begin
                    vel_next = 32'sh7FFF_FFFF;
                end else if (vel_shift < -48'sh0000_8000_0000) begin
                    vel_next = -32'sh8000_0000;
                end else begin
                    vel_next = vel_shift[31:0];
                end
                state_next = ST_POS_MUL;
            end
            ST_POS_MUL: begin
                prod_next  = 65'(vel_reg) * signed'({33'd0, dt_reg});
                state_next = ST_POS_ADD;
            end
            ST_POS_ADD: begin
                u_next = 46'(rd_data_reg.pos) + 46'(step_shift);
                if (track_reg[idx_addr] && due_reg) begin
                    state_next = (rd_data_reg.wrap == 31'd0) ? ST_WRAP_FIX : ST_WRAP_PREP;
                end else begin
                    newpos_next = rd_data_reg.pos;
                    rst_next    = 1'b0;
                    state_next  = ST_EMIT;
                end
            end
            ST_WRAP_PREP: begin
                neg_next   = wrap_arg[47];
                quo_next   = wrap_arg[47] ? ModW'(48'sd0 - wrap_arg) : ModW'(wrap_arg);
                rem_next   = '0;
                cnt_next   = 6'(ModW - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // One restoring step per cycle, most significant bit first.
                if (div_cand >= {1'b0, rd_data_reg.wrap}) begin
                    rem_next = 31'(div_cand - {1'b0, rd_data_reg.wrap});
                end else begin
                    rem_next = div_cand[30:0];
                end
                quo_next = {quo_reg[ModW-2:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    state_next = ST_WRAP_FIX;
                end
            end
            ST_WRAP_FIX: begin
                if (rd_data_reg.wrap == 31'd0) begin
                    // No wrap period: saturate the integrated position.
                    rst_next = 1'b0;
                    if (u_reg > 46'sh0000_7FFF_FFFF) begin
                        newpos_next = 32'sh7FFF_FFFF;
                    end else if (u_reg < -46'sh0000_8000_0000) begin
                        newpos_next = -32'sh8000_0000;
                    end else begin
                        newpos_next = u_reg[31:0];
                    end
                end else begin
                    newpos_next = wrapped[31:0];
                    rst_next    = (46'(wrapped) != u_reg);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // Write the entry back and hand the result to the output register.
                if (!m_valid_reg || m_ready) begin
                    mem_we       = 1'b1;
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_segment: 4'(idx_reg), velocity_command: vel_reg,
                                     reset_request: rst_reg, wrap_position: newpos_reg,
                                     last: !more_active};
                    idx_next     = idx_reg + CW'(1);
                    state_next   = ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Segment memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            seg_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= seg_mem[idx_addr];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            active_reg  <= '0;
            track_reg   <= '0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            active_reg  <= active_next;
            track_reg   <= track_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        dt_reg     <= dt_next;
        due_reg    <= due_next;
        drive_reg  <= drive_next;
        prod_reg   <= prod_next;
        vel_reg    <= vel_next;
        u_reg      <= u_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        newpos_reg <= newpos_next;
        rst_reg    <= rst_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ----- hw/rtl/gmaf_checker.sv -----
// Port-level checker for the geared modulo axis follower, bound to the top level.
module gmaf_checker
    import gmaf_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data,
    input logic      pready
);

    // A stalled result transaction holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // A load produces no result of its own.
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == OP_LOAD) && !m_valid |=> !m_valid)
        else $error("load produced a result");

    // A load is absorbed at once, so the input side stays open.
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == OP_LOAD) |=> s_ready)
        else $error("input blocked after load");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind geared_modulo_axis_follower gmaf_checker u_gmaf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

// ----- bench/tb_geared_modulo_axis_follower.sv -----
// Self-checking testbench for the geared modulo axis follower: segment loads, ticks and register settings.
`timescale 1ns / 1ps

module tb_geared_modulo_axis_follower;
    import gmaf_pkg::*;

    localparam int NumSeg = 16;
    localparam int SettleCycles = 1000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Mirror of the block's registers and segment table.
    logic        mir_enable;
    logic [30:0] mir_deadband;
    logic [31:0] mir_period;
    logic [31:0] mir_acc;
    logic        tab_active [NumSeg];
    logic        tab_tracks [NumSeg];
    logic signed [31:0] tab_ratio [NumSeg];
    logic [30:0] tab_wrap [NumSeg];
    logic signed [31:0] tab_pos [NumSeg];

    out_item_t   pending_results[$];
    int          error_count;
    bit          quiet_phase;
    int          receiver_hold;

    geared_modulo_axis_follower uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Work out the results of one accepted transaction and update the mirror.
    task automatic follow_item(in_item_t it);
        longint acc, drive, vel, u, p, half, r, w;
        logic [31:0] dt;
        bit due;
        int n;
        out_item_t res;
        if (it.opcode == OP_LOAD) begin
            tab_active[it.load_index] = it.load_valid;
            tab_tracks[it.load_index] = it.load_tracks;
            tab_ratio[it.load_index]  = it.load_ratio;
            tab_wrap[it.load_index]   = it.load_period;
            tab_pos[it.load_index]    = 0;
            return;
        end
        if (it.paused || !mir_enable) return;
        acc = longint'(mir_acc) + longint'(it.elapsed_time);
        if (acc > 64'sd4294967295) acc = 64'sd4294967295;
        mir_acc = acc[31:0];
        due = (mir_period == 0) || (mir_acc >= mir_period);
        dt = 0;
        if (due) begin
            dt = mir_acc;
            mir_acc = 0;
        end
        drive = longint'(it.drive_velocity);
        if ((drive < 0 ? -drive : drive) < longint'(mir_deadband)) drive = 0;
        n = 0;
        for (int i = 0; i < NumSeg; i++) begin
            if (!tab_active[i]) continue;
            vel = sat32((drive * longint'(tab_ratio[i])) >>> 16);
            res = '0;
            if (tab_tracks[i] && due) begin
                u = longint'(tab_pos[i]) + ((vel * longint'({32'd0, dt})) >>> 20);
                p = longint'(tab_wrap[i]);
                if (p == 0) begin
                    w = sat32(u);
                end else begin
                    half = p / 2;
                    r = (u + half) % p;
                    if (r < 0) r += p;
                    w = r - half;
                    res.reset_request = (w != u);
                end
                tab_pos[i] = w[31:0];
            end
            res.out_segment      = i[3:0];
            res.velocity_command = vel[31:0];
            res.wrap_position    = tab_pos[i];
            pending_results = {pending_results, res};
            n++;
        end
        if (n > 0) pending_results[$].last = 1'b1;
    endtask

    // Offer one transaction, hold it until accepted, then maybe leave a gap.
    task automatic send_item(in_item_t it);
        s_data  = it;
        s_valid = 1'b1;
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        follow_item(it);
        @(negedge aclk);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
    endtask

    task automatic end_of_traffic();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SettleCycles) @(negedge aclk);
    endtask

    // Register write, only while the block is idle.
    task automatic write_register(reg_idx_t idx, logic [31:0] value);
        end_of_traffic();
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_RUN_ENABLE: mir_enable   = value[0];
            REG_DEADBAND:   mir_deadband = value[30:0];
            default:        mir_period   = value;
        endcase
    endtask

    function automatic in_item_t load_item(logic [3:0] idx, logic vld, logic trk,
                                           logic [31:0] ratio, logic [30:0] per);
        in_item_t it;
        it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom,
                                            $urandom}));
        it.opcode = OP_LOAD;
        it.load_index = idx;
        it.load_valid = vld;
        it.load_tracks = trk;
        it.load_ratio = ratio;
        it.load_period = per;
        return it;
    endfunction

    function automatic in_item_t tick_item(logic psd, logic [31:0] et, logic [31:0] dv);
        in_item_t it;
        it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom,
                                            $urandom}));
        it.opcode = OP_TICK;
        it.paused = psd;
        it.elapsed_time = et;
        it.drive_velocity = dv;
        return it;
    endfunction

    function automatic in_item_t random_item();
        logic [31:0] et, dv, ratio;
        logic [30:0] per;
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
                0: ratio = $urandom;
                1: ratio = $urandom_range(0, 32'h3_0000) - 32'h1_8000;
                default: ratio = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            endcase
            case ($urandom_range(0, 3))
                0: per = 0;
                1: per = 31'($urandom);
                default: per = 31'($urandom_range(1, 32'h40_0000));
            endcase
            return load_item(4'($urandom_range(0, 15)), $urandom_range(0, 4) != 0,
                             1'($urandom_range(0, 1)), ratio, per);
        end
        case ($urandom_range(0, 3))
            0: et = $urandom;
            default: et = $urandom_range(0, 20000);
        endcase
        case ($urandom_range(0, 3))
            0: dv = $urandom;
            1: dv = $urandom_range(0, 4000) - 2000;
            default: dv = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        endcase
        return tick_item($urandom_range(0, 9) == 0, et, dv);
    endfunction

    // Results are compared with the oldest expectation at each accepting edge.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction for segment %0d", m_data.out_segment);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.out_segment !== want.out_segment) begin
                    $error("out_segment: expected %0d, got %0d",
                           want.out_segment, m_data.out_segment);
                    error_count++;
                end
                if (m_data.velocity_command !== want.velocity_command) begin
                    $error("velocity_command: expected %0d, got %0d",
                           want.velocity_command, m_data.velocity_command);
                    error_count++;
                end
                if (m_data.reset_request !== want.reset_request) begin
                    $error("reset_request: expected %0d, got %0d",
                           want.reset_request, m_data.reset_request);
                    error_count++;
                end
                if (m_data.wrap_position !== want.wrap_position) begin
                    $error("wrap_position: expected %0d, got %0d",
                           want.wrap_position, m_data.wrap_position);
                    error_count++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_data.last);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls in bursts, plus a long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (receiver_hold > 0) begin
                m_ready = 1'b0;
                receiver_hold--;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic test_extremes();
        write_register(REG_RUN_ENABLE, 32'd1);
        write_register(REG_DEADBAND, 32'd0);
        send_item(load_item(4'd0, 1'b1, 1'b1, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
        send_item(load_item(4'd1, 1'b1, 1'b1, 32'h8000_0000, 31'd1));
        send_item(load_item(4'd7, 1'b1, 1'b1, 32'h0001_0000, 31'd0));
        send_item(load_item(4'd9, 1'b1, 1'b0, 32'hFFFF_0000, 31'd5));
        send_item(load_item(4'd15, 1'b1, 1'b1, 32'h0000_8000, 31'h0010_0000));
        send_item(load_item(4'd3, 1'b0, 1'b1, 32'h1234_5678, 31'd100));
        send_item(tick_item(1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        send_item(tick_item(1'b0, 32'hFFFF_FFFF, 32'h8000_0000));
        send_item(tick_item(1'b0, 32'd0, 32'h0001_0000));
        send_item(tick_item(1'b1, 32'd1000, 32'h0001_0000));
        send_item(tick_item(1'b0, 32'd1048576, 32'hFFF0_0000));
        send_item(load_item(4'd7, 1'b1, 1'b1, 32'h0001_0000, 31'd0));
        send_item(tick_item(1'b0, 32'd12345, 32'h0000_0001));
    endtask

    task automatic test_deadband_and_disable();
        write_register(REG_DEADBAND, 32'h7FFF_FFFF);
        send_item(tick_item(1'b0, 32'd500, 32'h7FFF_FFFE));
        write_register(REG_DEADBAND, 32'd1311);
        send_item(tick_item(1'b0, 32'd500, 32'd1310));
        send_item(tick_item(1'b0, 32'd500, -32'sd1311));
        write_register(REG_RUN_ENABLE, 32'd0);
        send_item(tick_item(1'b0, 32'd500, 32'h0001_0000));
        write_register(REG_RUN_ENABLE, 32'd1);
    endtask

    task automatic test_no_active_segment();
        for (int i = 0; i < NumSeg; i++)
            send_item(load_item(i[3:0], 1'b0, 1'b0, 32'd0, 31'd0));
        write_register(REG_PERIOD, 32'd3000);
        send_item(tick_item(1'b0, 32'd2000, 32'h0001_0000));
        send_item(load_item(4'd2, 1'b1, 1'b1, 32'h0002_0000, 31'd0));
        send_item(tick_item(1'b0, 32'd2000, 32'h0001_0000));
        send_item(tick_item(1'b0, 32'hFFFF_FFFF, 32'h0001_0000));
        send_item(tick_item(1'b0, 32'hFFFF_FFFF, 32'h0001_0000));
    endtask

    task automatic test_random_phase(logic [31:0] period, logic [31:0] deadband, int count);
        write_register(REG_PERIOD, period);
        write_register(REG_DEADBAND, deadband);
        for (int i = 0; i < count; i++) send_item(random_item());
    endtask

    task automatic test_receiver_hold_off();
        receiver_hold = 3000;
        for (int i = 0; i < 30; i++) send_item(random_item());
        end_of_traffic();
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0;
        quiet_phase = 1'b0;
        receiver_hold = 0;
        mir_enable = 1'b0;
        mir_deadband = DeadbandReset;
        mir_period = 0;
        mir_acc = 0;
        for (int i = 0; i < NumSeg; i++) begin
            tab_active[i] = 1'b0;
            tab_tracks[i] = 1'b0;
            tab_ratio[i]  = 0;
            tab_wrap[i]   = 0;
            tab_pos[i]    = 0;
        end
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_extremes();
        test_deadband_and_disable();
        test_no_active_segment();
        test_random_phase(32'd0, 32'd1311, 90);
        test_receiver_hold_off();
        test_random_phase(32'd30000, 32'd0, 90);
        test_random_phase(32'hFFFF_FFFF, $urandom_range(0, 5000), 40);
        test_random_phase($urandom_range(1, 100000), $urandom, 60);
        quiet_phase = 1'b1;
        test_random_phase(32'd0, 32'd0, 80);
        end_of_traffic();

        if (pending_results.size() != 0) error_count++;
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- geared_modulo_axis_follower.f -----
hw/rtl/gmaf_pkg.sv
hw/rtl/geared_modulo_axis_follower.sv
hw/rtl/gmaf_checker.sv
bench/tb_geared_modulo_axis_follower.sv
